// ===== rtl/core/urtc_pkg.sv =====
// Package for the UART receive FIFO and text console core.
// Holds request/response beat types, function codes and register offsets.
// No dependencies.
`default_nettype none
package urtc_pkg;

   typedef enum logic [1:0] {
      FUNC_KEY   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_CELL  = 2'd3
   } func_type;

   localparam logic [3:0] OFS_DATA   = 4'h0;
   localparam logic [3:0] OFS_STATUS = 4'h6;
   localparam logic [3:0] OFS_ALWAYS = 4'hc;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [15:0] ALL_ONES  = 16'hffff;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] offset;
      logic [7:0] data;
      logic [4:0] cell_row;
      logic [6:0] cell_col;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic        scrolled;
      logic        key_dropped;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/urtc_front.sv =====
// Front end: accepts request beats into a two-entry queue.
// Depends on urtc_pkg.
`default_nettype none
module urtc_front
   import urtc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire req_type req_in,
   output logic         busy,
   input  wire logic    pop,
   output logic         q_valid,
   output req_type      q_head
);
   req_type     q_ff [2];
   req_type     q_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_head  = q_ff[0];

   // queue shift and fill
   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in  = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) q_in[0] = req_in;
         else q_in[1] = req_in;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/urtc_back.sv =====
// Back end: FIFO, console grid and response register, one beat per cycle.
// Depends on urtc_pkg.
`default_nettype none
module urtc_back
   import urtc_pkg::*;
#(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 32,
   parameter int FIFO_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire req_type q_head,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_out
);
   localparam int FW = $clog2(FIFO_DEPTH);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS + 1);
   localparam int AW = $clog2(ROWS * COLUMNS);

   logic [7:0]  fifo_mem [FIFO_DEPTH];
   logic [7:0]  grid_mem [ROWS * COLUMNS];
   logic [CW-1:0] rlen_ff [ROWS];
   logic [CW-1:0] rlen_in [ROWS];
   logic [FW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FW:0]   count_ff, count_in;
   logic [CW-1:0] cx_ff, cx_in;
   logic [RW-1:0] cy_ff, cy_in, base_ff, base_in;

   // stage 2 holding register: metadata; memory read data comes late
   logic         s2_valid_ff;
   rsp_type      s2_ff, s2_in;
   logic         s2_fifo_ff, s2_fifo_in, s2_cell_ff, s2_cell_in;
   logic [7:0]   fifo_q_ff, grid_q_ff;

   logic         fifo_we, grid_we;
   logic [AW-1:0] grid_wa, grid_ra;
   logic [RW-1:0] pr, cpr;
   logic [RW:0]   sum;
   logic         nl;
   req_type      r;

   assign pop = q_valid;
   assign r   = q_head;

   function automatic logic [RW-1:0] wrap(input logic [RW:0] v);
      wrap = (v >= (RW+1)'(ROWS)) ? RW'(v - (RW+1)'(ROWS)) : v[RW-1:0];
   endfunction

   // execute one beat
   always_comb begin
      head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      cx_in = cx_ff; cy_in = cy_ff; base_in = base_ff;
      for (int i = 0; i < ROWS; i++) rlen_in[i] = rlen_ff[i];
      s2_in = '0; s2_fifo_in = 1'b0; s2_cell_in = 1'b0;
      fifo_we = 1'b0; grid_we = 1'b0; nl = 1'b0;
      pr  = wrap({1'b0, base_ff} + {1'b0, cy_ff});
      grid_wa = AW'(pr * COLUMNS + cx_ff);
      sum = {1'b0, base_ff} + (RW+1)'(r.cell_row);
      cpr = wrap(sum);
      grid_ra = AW'(cpr * COLUMNS + r.cell_col);
      if (q_valid) begin
         unique case (func_type'(r.func))
            FUNC_KEY: begin
               if (count_ff == (FW+1)'(FIFO_DEPTH)) s2_in.key_dropped = 1'b1;
               else begin
                  fifo_we = 1'b1;
                  tail_in = (tail_ff == FW'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_READ: begin
               if (r.offset == OFS_DATA) begin
                  if (count_ff != '0) begin
                     s2_fifo_in = 1'b1;
                     head_in = (head_ff == FW'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in = count_ff - 1'b1;
                  end
               end else if (r.offset == OFS_STATUS) begin
                  s2_in.read_data = (count_ff != '0) ? ALL_ONES : 16'd0;
               end else if (r.offset == OFS_ALWAYS) begin
                  s2_in.read_data = ALL_ONES;
               end
            end
            FUNC_WRITE: begin
               if (r.offset == OFS_DATA) begin
                  s2_in.tx_valid = 1'b1;
                  s2_in.tx_byte  = r.data;
                  if (r.data == CHAR_LF) nl = 1'b1;
                  else if (r.data != CHAR_CR) begin
                     grid_we = 1'b1;
                     cx_in = cx_ff + 1'b1;
                     rlen_in[pr] = cx_ff + 1'b1;
                     if (cx_in >= CW'(COLUMNS)) nl = 1'b1;
                  end
                  if (nl) begin
                     cx_in = '0;
                     if (cy_ff == RW'(ROWS - 1)) begin
                        base_in = wrap({1'b0, base_ff} + 1'b1);
                        s2_in.scrolled = 1'b1;
                        rlen_in[base_ff] = '0;
                     end else begin
                        cy_in = cy_ff + 1'b1;
                        rlen_in[wrap({1'b0, pr} + 1'b1)] = '0;
                     end
                  end
               end
            end
            default: begin
               if (32'(r.cell_row) < ROWS && 32'(r.cell_col) < 32'(rlen_ff[cpr]))
                  s2_cell_in = 1'b1;
            end
         endcase
      end
      s2_in.cursor_row = 5'(cy_in);
      s2_in.cursor_col = 7'(cx_in);
   end

   // memories
   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[tail_ff] <= r.data;
      fifo_q_ff <= fifo_mem[head_ff];
      if (grid_we) grid_mem[grid_wa] <= r.data;
      grid_q_ff <= grid_mem[grid_ra];
   end

   always_ff @(posedge clock) begin
      s2_ff <= s2_in; s2_fifo_ff <= s2_fifo_in; s2_cell_ff <= s2_cell_in;
      if (reset) begin
         head_ff <= '0; tail_ff <= '0; count_ff <= '0;
         cx_ff <= '0; cy_ff <= '0; base_ff <= '0; s2_valid_ff <= 1'b0;
         for (int i = 0; i < ROWS; i++) rlen_ff[i] <= '0;
      end else begin
         head_ff <= head_in; tail_ff <= tail_in; count_ff <= count_in;
         cx_ff <= cx_in; cy_ff <= cy_in; base_ff <= base_in;
         s2_valid_ff <= q_valid;
         for (int i = 0; i < ROWS; i++) rlen_ff[i] <= rlen_in[i];
      end
   end

   // merge late read data
   always_comb begin
      rsp_out = s2_ff;
      if (s2_fifo_ff) rsp_out.read_data = {8'd0, fifo_q_ff};
      if (s2_cell_ff) rsp_out.read_data = {8'd0, grid_q_ff};
   end
   assign rsp_valid = s2_valid_ff;
endmodule
`default_nettype wire

// ===== rtl/core/uart_rx_fifo_text_console_core.sv =====
// Channel   Ports                     Handshake
// request   req_data                  start & !busy
// response  rsp_data                  rsp_strobe, one cycle
// One beat enters the back end per cycle; a response follows acceptance
// through the front queue, then the memory read register.
// Synchronous active-high reset clears pointers, cursor and row lengths.
// busy comes from the two-entry front queue, which the back end drains every
// cycle, so busy stays low; the receiver cannot stall.
// Depends on urtc_pkg, urtc_front, urtc_back.
`default_nettype none
module uart_rx_fifo_text_console_core
   import urtc_pkg::*;
#(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 32,
   parameter int FIFO_DEPTH = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);
   logic    q_valid, pop;
   req_type q_head;

   urtc_front u_front (
      .clock, .reset, .start, .req_in(req_data), .busy,
      .pop, .q_valid, .q_head
   );

   urtc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_head, .pop,
      .rsp_valid(rsp_strobe), .rsp_out(rsp_data)
   );
endmodule
`default_nettype wire

// ===== rtl/core/urtc_checker.sv =====
// Port-level assertions for the console core, bound to the top level.
// Depends on urtc_pkg.
`default_nettype none
module urtc_sva
   import urtc_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);
   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe) else $error("strobe right after reset");
   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'd0)
      else $error("tx_byte without tx_valid");
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.key_dropped && rsp_data.tx_valid))
      else $error("drop and transmit together");
   a_scroll_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.scrolled |-> rsp_data.tx_valid &&
      rsp_data.cursor_col == 7'd0) else $error("bad scroll");
   // every accepted beat is answered by a response strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##2 rsp_strobe) else $error("missing response");
endmodule

bind uart_rx_fifo_text_console_core urtc_sva u_checker (.*);
`default_nettype wire

// ===== test/urtc_checker.sv =====
// Checker for the UART receive FIFO / text console core: watches both channels,
// predicts each response beat and compares it field by field.
// Depends on urtc_pkg.
`timescale 1ns / 1ps
module urtc_checker
   import urtc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_strobe,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);
   localparam int NCOL = 80;
   localparam int NROW = 32;

   // predicted copy of the block state
   logic [7:0] fifo_mem [256];
   logic [7:0] fifo_rd_ptr, fifo_wr_ptr;
   logic [8:0] fifo_fill;
   logic [7:0] grid [NROW][NCOL];
   logic [6:0] line_len [NROW];
   logic [6:0] cur_col;
   logic [4:0] cur_row;
   logic [4:0] top_row;

   rsp_type rsp_queue [$];

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // draw one byte on the console; returns 1 on scroll
   function automatic logic draw_char(input logic [7:0] ch);
      logic       scr;
      logic       nl;
      logic [4:0] pr;
      scr = 1'b0;
      nl  = 1'b0;
      if (ch == CHAR_LF) begin
         nl = 1'b1;
      end else if (ch != CHAR_CR) begin
         pr = top_row + cur_row;
         if (cur_col < NCOL) begin
            grid[pr][cur_col] = ch;
            cur_col = 7'(cur_col + 7'd1);
            line_len[pr] = cur_col;
         end
         if (cur_col >= NCOL) nl = 1'b1;
      end
      if (nl) begin
         cur_col = 7'd0;
         if (cur_row == NROW - 1) begin
            top_row = 5'(top_row + 5'd1);
            scr = 1'b1;
         end else begin
            cur_row = 5'(cur_row + 5'd1);
         end
         line_len[5'(top_row + cur_row)] = 7'd0;
      end
      return scr;
   endfunction

   function automatic rsp_type predict_rsp(input req_type r);
      rsp_type    p;
      logic [4:0] pr;
      p = '0;
      case (func_type'(r.func))
         FUNC_KEY: begin
            if (fifo_fill >= 256) begin
               p.key_dropped = 1'b1;
            end else begin
               fifo_mem[fifo_wr_ptr] = r.data;
               fifo_wr_ptr = 8'(fifo_wr_ptr + 8'd1);
               fifo_fill = 9'(fifo_fill + 9'd1);
            end
         end
         FUNC_READ: begin
            if (r.offset == OFS_DATA) begin
               if (fifo_fill > 0) begin
                  p.read_data = {8'd0, fifo_mem[fifo_rd_ptr]};
                  fifo_rd_ptr = 8'(fifo_rd_ptr + 8'd1);
                  fifo_fill = 9'(fifo_fill - 9'd1);
               end
            end else if (r.offset == OFS_STATUS) begin
               p.read_data = (fifo_fill > 0) ? ALL_ONES : 16'd0;
            end else if (r.offset == OFS_ALWAYS) begin
               p.read_data = ALL_ONES;
            end
         end
         FUNC_WRITE: begin
            if (r.offset == OFS_DATA) begin
               p.tx_valid = 1'b1;
               p.tx_byte  = r.data;
               p.scrolled = draw_char(r.data);
            end
         end
         default: begin
            pr = top_row + r.cell_row;
            if (r.cell_col < line_len[pr] && r.cell_col < NCOL)
               p.read_data = {8'd0, grid[pr][r.cell_col]};
         end
      endcase
      p.cursor_row = cur_row;
      p.cursor_col = cur_col;
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fifo_rd_ptr = 8'd0;
         fifo_wr_ptr = 8'd0;
         fifo_fill   = 9'd0;
         cur_col     = 7'd0;
         cur_row     = 5'd0;
         top_row     = 5'd0;
         for (int i = 0; i < NROW; i++) line_len[i] = 7'd0;
         rsp_queue.delete();
      end else begin
         // response beat against oldest prediction
         if (rsp_strobe) begin
            if (rsp_queue.size() == 0) begin
               report("unexpected response", 16'(rsp_data.read_data), 16'd0);
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report("read_data", rsp_data.read_data, want.read_data);
               if (rsp_data.tx_valid !== want.tx_valid)
                  report("tx_valid", 16'(rsp_data.tx_valid), 16'(want.tx_valid));
               if (rsp_data.tx_byte !== want.tx_byte)
                  report("tx_byte", 16'(rsp_data.tx_byte), 16'(want.tx_byte));
               if (rsp_data.cursor_row !== want.cursor_row)
                  report("cursor_row", 16'(rsp_data.cursor_row), 16'(want.cursor_row));
               if (rsp_data.cursor_col !== want.cursor_col)
                  report("cursor_col", 16'(rsp_data.cursor_col), 16'(want.cursor_col));
               if (rsp_data.scrolled !== want.scrolled)
                  report("scrolled", 16'(rsp_data.scrolled), 16'(want.scrolled));
               if (rsp_data.key_dropped !== want.key_dropped)
                  report("key_dropped", 16'(rsp_data.key_dropped), 16'(want.key_dropped));
            end
         end
         // accepted request beat
         if (start && !busy) rsp_queue.push_back(predict_rsp(req_data));
      end
      pending = rsp_queue.size();
   end
endmodule

// ===== test/tb.sv =====
// Testbench top for uart_rx_fifo_text_console_core: clock, reset, stimulus
// and verdict. Depends on urtc_pkg, the core and urtc_checker.
`timescale 1ns / 1ps
module tb;
   import urtc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count;
   int      beat_count;
   bit      calm;

   uart_rx_fifo_text_console_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   urtc_checker u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("uart_rx_fifo_text_console_core verification failed");
            $finish;
         end
      end
   end

   function automatic req_type mk(input func_type f, input logic [3:0] o,
                                  input logic [7:0] d, input logic [4:0] r,
                                  input logic [6:0] c);
      req_type q;
      q.func = f; q.offset = o; q.data = d; q.cell_row = r; q.cell_col = c;
      return q;
   endfunction

   // one request beat, then maybe a random gap
   task automatic send(input req_type q);
      start    <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      beat_count++;
      if (!calm && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [3:0] pick_offset();
      case ($urandom_range(0, 4))
         0, 1: return OFS_DATA;
         2: return OFS_STATUS;
         3: return OFS_ALWAYS;
         default: return 4'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 9))
         0: return CHAR_LF;
         1: return CHAR_CR;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type noise_beat();
      return mk(func_type'($urandom_range(0, 3)), 4'($urandom), 8'($urandom),
                5'($urandom), 7'($urandom));
   endfunction

   initial begin
      int n;
      req_type q;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      beat_count = 0;
      calm       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, keys, offsets, console specials
      send(mk(FUNC_READ, OFS_DATA, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_READ, OFS_STATUS, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_READ, OFS_ALWAYS, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_READ, 4'hf, 8'hff, 5'd31, 7'd127));
      send(mk(FUNC_KEY, 4'hf, 8'h00, 5'd31, 7'd127));
      send(mk(FUNC_KEY, 4'h0, 8'hff, 5'd0, 7'd0));
      send(mk(FUNC_READ, OFS_STATUS, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_READ, OFS_DATA, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_READ, OFS_DATA, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_WRITE, OFS_DATA, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_WRITE, OFS_DATA, 8'hff, 5'd0, 7'd0));
      send(mk(FUNC_WRITE, OFS_DATA, CHAR_CR, 5'd0, 7'd0));
      send(mk(FUNC_WRITE, 4'h3, 8'h41, 5'd0, 7'd0));
      send(mk(FUNC_CELL, 4'h0, 8'h00, 5'd0, 7'd0));
      send(mk(FUNC_CELL, 4'h0, 8'h00, 5'd0, 7'd1));
      send(mk(FUNC_CELL, 4'h0, 8'h00, 5'd0, 7'd2));
      send(mk(FUNC_CELL, 4'h0, 8'h00, 5'd31, 7'd127));
      send(mk(FUNC_WRITE, OFS_DATA, CHAR_LF, 5'd0, 7'd0));
      send(mk(FUNC_CELL, 4'h0, 8'h00, 5'd1, 7'd0));

      // hold off until every directed beat has been answered
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);

      // random: bursts of well-formed activity, some noise
      while (beat_count < 1150) begin
         calm = (beat_count > 450 && beat_count < 650);
         case ($urandom_range(0, 9))
            0, 1: begin // key burst, sometimes long enough to fill the FIFO
               n = ($urandom_range(0, 5) == 0) ? $urandom_range(240, 280)
                                                : $urandom_range(1, 30);
               repeat (n) send(mk(FUNC_KEY, 4'($urandom), 8'($urandom),
                                  5'($urandom), 7'($urandom)));
            end
            2, 3: begin // register reads
               repeat ($urandom_range(1, 30))
                  send(mk(FUNC_READ, pick_offset(), 8'($urandom),
                          5'($urandom), 7'($urandom)));
            end
            4, 5, 6: begin // text output, with long lines at times
               repeat ($urandom_range(1, 100))
                  send(mk(FUNC_WRITE, ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                                  : OFS_DATA,
                          pick_char(), 5'($urandom), 7'($urandom)));
            end
            7, 8: begin // cell reads, mostly in range
               repeat ($urandom_range(1, 20)) begin
                  q = mk(FUNC_CELL, 4'($urandom), 8'($urandom), 5'($urandom),
                         ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                     : 7'($urandom_range(0, 85)));
                  send(q);
               end
            end
            default: begin
               repeat ($urandom_range(1, 10)) send(noise_beat());
            end
         endcase
         // hold off until the block has drained
         if ($urandom_range(0, 29) == 0) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("uart_rx_fifo_text_console_core verification clean");
      else
         $display("uart_rx_fifo_text_console_core verification failed");
      $finish;
   end
endmodule
